// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers; expect clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/psf_pkg.sv =====
package psf_pkg;

	localparam logic [1:0] CMD_FORMAT = 2'd0;
	localparam logic [1:0] CMD_STRING = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_S       = 8'h73;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2d;

	localparam int CNT_W     = 31;
	localparam int DIG_DEPTH = 10;
	localparam int DIG_W     = $clog2(DIG_DEPTH + 1);
	localparam int HEX_DIGS  = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	// floor(x / 10) == (x * RECIP10) >> 35 for every 32-bit x
	localparam logic [31:0] RECIP10 = 32'hcccc_cccd;

	localparam logic [7:0] HEX_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ECHO,
		KIND_PCT,
		KIND_DEC,
		KIND_HEX,
		KIND_DROP,
		KIND_FINISH
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SKIP,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic mul_step;
		logic div_step;
		logic skip_step;
		logic emit_step;
	} ctl_cmd_t;

	typedef struct packed {
		item_kind_t kind;
		logic       q_zero;
		logic       cnt_one;
		logic       top_zero;
		logic       out_free;
	} dp_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return HEX_CHARS[d];
	endfunction

endpackage

// ===== hdl/psf_if.sv =====
interface psf_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic [31:0] arg_word;

	modport source (output valid, command, data_byte, arg_word, input ready);
	modport sink (input valid, command, data_byte, arg_word, output ready);
endinterface

interface psf_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [30:0] out_count;
	logic        is_count;
	logic        last;

	modport source (output valid, out_byte, out_count, is_count, last, input ready);
	modport sink (input valid, out_byte, out_count, is_count, last, output ready);
endinterface

// ===== hdl/psf_ctrl.sv =====
`include "assert_macros.svh"

module psf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psf_pkg::dp_status_t status,
	output psf_pkg::ctl_cmd_t   cmd
);
	import psf_pkg::*;

	ctl_state_t state_q, state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.kind == KIND_DEC) begin
					state_d = ST_MUL;
				end else if (accept && status.kind == KIND_HEX) begin
					state_d = ST_SKIP;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				state_d = status.q_zero ? ST_EMIT : ST_MUL;
			end
			ST_SKIP: begin
				if (status.cnt_one || !status.top_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.accept    = accept;
			ST_MUL:  cmd.mul_step  = 1'b1;
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_SKIP: cmd.skip_step = !status.cnt_one && status.top_zero;
			ST_EMIT: cmd.emit_step = status.out_free;
			default: cmd = '0;
		endcase
	end

	`ASSERT_AT(a_div_after_mul, state_q == ST_DIV |-> $past(state_q) == ST_MUL,
		"division step without a preceding multiply")
	`ASSERT_AT(a_emit_done_idle, cmd.emit_step && status.cnt_one |=> state_q == ST_IDLE,
		"last digit did not return to idle")
	`ASSERT_NEVER(a_one_cmd, !$onehot0(cmd), "more than one datapath command")
endmodule

// ===== hdl/psf_dp.sv =====
`include "assert_macros.svh"

module psf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          command,
	input  logic [7:0]          data_byte,
	input  logic [31:0]         arg_word,
	input  psf_pkg::ctl_cmd_t   cmd,
	output psf_pkg::dp_status_t status,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [7:0]          out_byte,
	output logic [30:0]         out_count,
	output logic                is_count,
	output logic                last
);
	import psf_pkg::*;

	logic             pending_q;
	logic [CNT_W-1:0] count_q;
	logic [DIG_W-1:0] cnt_q;
	logic [31:0]      mag_q;
	logic [63:0]      prod_q;
	logic [3:0]       dig_q [DIG_DEPTH];

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [CNT_W-1:0] out_count_q;
	logic             is_count_q;
	logic             last_q;

	item_kind_t       kind;
	logic             neg;
	logic [28:0]      quo;
	logic [3:0]       q10_lo;
	logic [3:0]       digit;
	logic             ld;
	logic [7:0]       ld_byte;
	logic             ld_isc;
	logic             ld_last;
	logic             out_free;

	always_comb begin
		kind = KIND_NONE;
		unique case (command)
			CMD_FORMAT: begin
				if (pending_q) begin
					if (data_byte == CH_D) begin
						kind = KIND_DEC;
					end else if (data_byte == CH_X) begin
						kind = KIND_HEX;
					end else begin
						kind = KIND_DROP;
					end
				end else if (data_byte == CH_PERCENT) begin
					kind = KIND_PCT;
				end else begin
					kind = KIND_ECHO;
				end
			end
			CMD_STRING: kind = KIND_ECHO;
			CMD_FINISH: kind = KIND_FINISH;
			default:    kind = KIND_NONE;
		endcase
	end

	assign neg    = arg_word[31];
	assign quo    = prod_q[63:35];
	assign q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
	assign digit  = mag_q[3:0] - q10_lo;

	always_comb begin
		ld      = 1'b0;
		ld_byte = '0;
		ld_isc  = 1'b0;
		ld_last = 1'b1;
		if (cmd.accept) begin
			unique case (kind)
				KIND_ECHO: begin
					ld      = 1'b1;
					ld_byte = data_byte;
				end
				KIND_DEC: begin
					ld      = neg;
					ld_byte = CH_MINUS;
					ld_last = 1'b0;
				end
				KIND_FINISH: begin
					ld     = 1'b1;
					ld_isc = 1'b1;
				end
				default: ld = 1'b0;
			endcase
		end else if (cmd.emit_step) begin
			ld      = 1'b1;
			ld_byte = hex_char(dig_q[0]);
			ld_last = (cnt_q == DIG_W'(1));
		end
	end

	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			count_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ld && ld_isc) begin
				count_q <= '0;
			end else if (ld && count_q != COUNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.accept) begin
				unique case (kind)
					KIND_PCT:                       pending_q <= 1'b1;
					KIND_DEC, KIND_HEX, KIND_DROP,
					KIND_FINISH:                    pending_q <= 1'b0;
					default:                        pending_q <= pending_q;
				endcase
				if (kind == KIND_DEC) begin
					cnt_q <= '0;
				end else if (kind == KIND_HEX) begin
					cnt_q <= DIG_W'(HEX_DIGS);
				end
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + DIG_W'(1);
			end else if (cmd.skip_step || cmd.emit_step) begin
				cnt_q <= cnt_q - DIG_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_byte_q  <= ld_byte;
			out_count_q <= ld_isc ? count_q : '0;
			is_count_q  <= ld_isc;
			last_q      <= ld_last;
		end
		if (cmd.accept && kind == KIND_DEC) begin
			mag_q <= neg ? (32'd0 - arg_word) : arg_word;
		end else if (cmd.div_step) begin
			mag_q <= {3'b000, quo};
		end
		if (cmd.mul_step) begin
			prod_q <= mag_q * RECIP10;
		end
		if (cmd.accept && kind == KIND_HEX) begin
			for (int i = 0; i < DIG_DEPTH; i++) begin
				if (i < HEX_DIGS) begin
					dig_q[i] <= arg_word[4*(HEX_DIGS-1-i) +: 4];
				end else begin
					dig_q[i] <= '0;
				end
			end
		end else if (cmd.div_step) begin
			dig_q[0] <= digit;
			for (int i = 1; i < DIG_DEPTH; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end else if (cmd.skip_step || cmd.emit_step) begin
			for (int i = 0; i < DIG_DEPTH - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
			dig_q[DIG_DEPTH-1] <= '0;
		end
	end

	assign status.kind     = kind;
	assign status.q_zero   = (quo == '0);
	assign status.cnt_one  = (cnt_q == DIG_W'(1));
	assign status.top_zero = (dig_q[0] == 4'd0);
	assign status.out_free = out_free;

	assign res_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_count = out_count_q;
	assign is_count  = is_count_q;
	assign last      = last_q;

	`ASSERT_NEVER(a_load_blocked, ld && !out_free, "result overwritten before it was taken")
	`ASSERT_AT(a_cnt_range, cnt_q <= DIG_W'(DIG_DEPTH), "digit count beyond buffer depth")
	`ASSERT_NEVER(a_pop_empty, (cmd.skip_step || cmd.emit_step) && cnt_q == '0,
		"digit popped from an empty buffer")
	`ASSERT_AT(a_div_no_overflow, cmd.div_step |-> cnt_q < DIG_W'(DIG_DEPTH),
		"decimal digit pushed into a full buffer")
endmodule

// ===== hdl/printf_subset_formatter_core.sv =====
// Formats a byte stream under a printf subset (%d, %x, %s) and emits one
// character beat per cycle on the result channel while it is not stalled,
// each marked last on the final character of its item; a finish item returns
// the saturating count of characters since the previous finish. Plain,
// string and finish items load their result as they are accepted. A %x item
// is accepted, skips leading zero nibbles, starts output, and emits one hex
// digit per step. A %d item is accepted, then runs the shared 32x32
// reciprocal multiply and its remainder step for each decimal digit, then
// emits its digits one per step. Results leave through
// a single output register, so stalls on the result side hold the block.
module printf_subset_formatter_core (
	input logic          clk,
	input logic          arst_n,
	psf_item_if.sink     item,
	psf_result_if.source result
);
	import psf_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	psf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	psf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (item.command),
		.data_byte (item.data_byte),
		.arg_word  (item.arg_word),
		.cmd       (cmd),
		.status    (status),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.out_byte  (result.out_byte),
		.out_count (result.out_count),
		.is_count  (result.is_count),
		.last      (result.last)
	);
endmodule
